[sv/quoted_backslash_escape_fixer_unit_macros.svh]
// assertion macros shared by the checker
`ifndef QUOTED_BACKSLASH_ESCAPE_FIXER_UNIT_MACROS_SVH
`define QUOTED_BACKSLASH_ESCAPE_FIXER_UNIT_MACROS_SVH

// condition must hold at every edge outside the disable term
`define QBEF_ASSERT_ALWAYS(lbl, clk, dis, cond) \
  lbl: assert property (@(posedge clk) disable iff (dis) (cond)) \
    else $error("qbef assertion failed");

// consequent must hold at the next edge after the antecedent
`define QBEF_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("qbef assertion failed");

`endif

[sv/qbef_pkg.sv]
`default_nettype none
package qbef_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int FIX_W       = 24;
  localparam int CNT_EXT_W   = 32;
  localparam int CQ_AW       = 1;
  localparam int CQ_DEPTH    = 1 << CQ_AW;

  localparam logic [FIX_W-1:0] FIX_MAX = '1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_last;
    logic [FIX_W-1:0] fix_total;
  } out_beat_t;

  // one classified input beat: nbs leading backslashes, then data
  typedef struct packed {
    logic [1:0]       nbs;
    logic [7:0]       data;
    logic             last;
    logic [FIX_W-1:0] total;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cq_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cq_rd_t;

endpackage
`default_nettype wire

[sv/qbef_front.sv]
`default_nettype none
module qbef_front import qbef_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_beat_t in_beat,
  input  wire logic     cq_full,
  output cq_wr_t        wr
);

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'b001,
    MODE_COMMENT = 3'b010,
    MODE_STRING  = 3'b100
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic                   quote_single_r, quote_single_nxt;
  logic                   held_r, held_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  function automatic logic is_fix_lead(input logic [7:0] c);
    is_fix_lead = (c >= CH_ZERO && c <= CH_NINE) || c == CH_LX || c == CH_UX ||
                  c == CH_LU || c == CH_UU;
  endfunction

  always_comb begin
    logic [7:0]             c;
    logic [7:0]             q;
    logic                   acc;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic [CNT_EXT_W-1:0]   cnt_ext;
    c                = in_beat.in_byte;
    q                = quote_single_r ? CH_SQUOTE : CH_DQUOTE;
    acc              = in_push && !cq_full;
    mode_nxt         = mode_r;
    quote_single_nxt = quote_single_r;
    held_nxt         = held_r;
    cnt_upd          = cnt_r;
    wr.push          = 1'b0;
    wr.cmd.nbs       = 2'd0;
    wr.cmd.data      = c;
    wr.cmd.last      = in_beat.in_last;
    wr.cmd.total     = '0;
    if (acc) begin
      if (held_r) begin
        held_nxt = 1'b0;
        wr.push  = 1'b1;
        if (is_fix_lead(c)) begin
          wr.cmd.nbs = 2'd2;
          if (cnt_r != '1) begin
            cnt_upd = cnt_r + 1'b1;
          end
        end else begin
          wr.cmd.nbs = 2'd1;
        end
      end else begin
        case (mode_r)
          MODE_COMMENT: begin
            wr.push = 1'b1;
            if (c == CH_NL) begin
              mode_nxt = MODE_PLAIN;
            end
          end
          MODE_STRING: begin
            if (c == q) begin
              wr.push  = 1'b1;
              mode_nxt = MODE_PLAIN;
            end else if (c == CH_BSLASH && !in_beat.in_last) begin
              held_nxt = 1'b1;
            end else begin
              wr.push = 1'b1;
            end
          end
          default: begin
            wr.push = 1'b1;
            if (c == CH_HASH) begin
              mode_nxt = MODE_COMMENT;
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
              mode_nxt         = MODE_STRING;
              quote_single_nxt = (c == CH_SQUOTE);
            end
          end
        endcase
      end
    end
    cnt_ext = CNT_EXT_W'(cnt_upd);
    cnt_nxt = cnt_upd;
    if (acc && in_beat.in_last) begin
      wr.cmd.total     = (cnt_ext > CNT_EXT_W'(FIX_MAX)) ? FIX_MAX : cnt_ext[FIX_W-1:0];
      mode_nxt         = MODE_PLAIN;
      quote_single_nxt = 1'b0;
      held_nxt         = 1'b0;
      cnt_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_PLAIN;
      quote_single_r <= 1'b0;
      held_r         <= 1'b0;
      cnt_r          <= '0;
    end else begin
      mode_r         <= mode_nxt;
      quote_single_r <= quote_single_nxt;
      held_r         <= held_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/qbef_cmd_fifo.sv]
`default_nettype none
module qbef_cmd_fifo import qbef_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cq_wr_t wr,
  output logic        full,
  input  wire logic   pop,
  output cq_rd_t      rd
);

  cmd_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wptr_r, wptr_nxt;
  logic [CQ_AW-1:0] rptr_r, rptr_nxt;
  logic [CQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (CQ_AW + 1)'(CQ_DEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.cmd   = mem_r[rptr_r];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd.valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/qbef_back.sv]
`default_nettype none
module qbef_back import qbef_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cq_rd_t rd,
  output logic        cq_pop,
  input  wire logic   out_pop,
  output logic        out_empty,
  output out_beat_t   out_beat
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r;
  logic [1:0] idx_r, idx_nxt;
  logic      load;
  logic      at_data;
  out_beat_t beat_nxt;

  assign load      = rd.valid && (!out_valid_r || out_pop);
  assign at_data   = (idx_r == rd.cmd.nbs);
  assign cq_pop    = load && at_data;
  assign out_empty = !out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    beat_nxt.out_byte  = at_data ? rd.cmd.data : CH_BSLASH;
    beat_nxt.out_last  = at_data && rd.cmd.last;
    beat_nxt.fix_total = (at_data && rd.cmd.last) ? rd.cmd.total : '0;
    idx_nxt            = idx_r;
    if (load) begin
      idx_nxt = at_data ? 2'd0 : idx_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/quoted_backslash_escape_fixer_unit.sv]
// each pushed command goes through the command queue into the output register
// throughput: one in beat per cycle while in_full is low; the out side gives one
// byte per cycle while popped, so a beat expanding into two or three bytes holds
// the back end; the command queue between front and back is two entries deep
// reset: synchronous active-low rst_n clears lexer state, fix count,
// queue and output valid flag
`default_nettype none
module quoted_backslash_escape_fixer_unit import qbef_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_beat_t in_beat,
  input  wire logic     out_pop,
  output logic          out_empty,
  output out_beat_t     out_beat
);

  cq_wr_t wr;
  cq_rd_t rd;
  logic   cq_full;
  logic   cq_pop;

  assign in_full = cq_full;

  qbef_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_beat (in_beat),
    .cq_full (cq_full),
    .wr      (wr)
  );

  qbef_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .full  (cq_full),
    .pop   (cq_pop),
    .rd    (rd)
  );

  qbef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (rd),
    .cq_pop    (cq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

[sv/qbef_checker.sv]
`default_nettype none
`include "quoted_backslash_escape_fixer_unit_macros.svh"
module qbef_checker import qbef_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_push,
  input wire logic      in_full,
  input wire in_beat_t  in_beat,
  input wire logic      out_pop,
  input wire logic      out_empty,
  input wire out_beat_t out_beat
);

  // fix count only rides on the final beat of a text
  `QBEF_ASSERT_ALWAYS(a_total_only_last, clk, !rst_n,
    out_empty || out_beat.out_last || out_beat.fix_total == '0)

  // reset leaves both sides free
  `QBEF_ASSERT_NEXT(a_reset_clear, clk, 1'b0, !rst_n, out_empty && !in_full)

  // a waiting beat holds until popped
  `QBEF_ASSERT_NEXT(a_out_hold, clk, !rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_beat))

endmodule

bind quoted_backslash_escape_fixer_unit qbef_checker u_qbef_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_beat   (in_beat),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_beat  (out_beat)
);
`default_nettype wire
